### hw/rtl/kfkd_pkg.sv
// Package for the keyboard frame key decoder: widths, frame layout constants,
// key codes, status and register-index enums and the shared frame view struct.
// No dependencies.
`default_nettype none

package kfkd_pkg;

   // Frame layout
   localparam int FRAME_LENGTH = 11;   // bytes per frame, 6..16
   localparam int CNT_W        = $clog2(FRAME_LENGTH);

   localparam logic [CNT_W-1:0] SYNC_POS  = CNT_W'(0);
   localparam logic [CNT_W-1:0] ADDR_POS  = CNT_W'(2);
   localparam logic [CNT_W-1:0] OPHI_POS  = CNT_W'(3);
   localparam logic [CNT_W-1:0] OPLO_POS  = CNT_W'(4);
   localparam logic [CNT_W-1:0] DATA_POS  = CNT_W'(5);
   localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(FRAME_LENGTH - 1);

   localparam logic [7:0] SYNC_BYTE = 8'h55;

   // Opcode high byte values
   localparam logic [7:0] OPHI_NAV    = 8'h00;
   localparam logic [7:0] OPHI_ENTER  = 8'h01;
   localparam logic [7:0] OPHI_REWIND = 8'h02;
   localparam logic [7:0] OPHI_NUMBER = 8'h20;
   localparam logic [7:0] OPHI_RETURN = 8'h25;
   localparam logic [7:0] OPHI_PAUSE  = 8'h80;

   // Opcode low byte values under OPHI_NAV
   localparam logic [7:0] OPLO_RIGHT = 8'h02;
   localparam logic [7:0] OPLO_LEFT  = 8'h04;
   localparam logic [7:0] OPLO_UP    = 8'h08;
   localparam logic [7:0] OPLO_DOWN  = 8'h10;
   localparam logic [7:0] OPLO_FFWD  = 8'h20;
   localparam logic [7:0] OPLO_SETUP = 8'h5D;

   // Number key data range
   localparam logic [7:0] NUM_FIRST = 8'h01;
   localparam logic [7:0] NUM_LAST  = 8'h18;

   // Key codes
   localparam int KEY_W = 6;
   localparam logic [KEY_W-1:0] KEY_NONE     = 6'd0;
   localparam logic [KEY_W-1:0] KEY_RIGHT    = 6'd1;
   localparam logic [KEY_W-1:0] KEY_LEFT     = 6'd2;
   localparam logic [KEY_W-1:0] KEY_FFWD     = 6'd3;
   localparam logic [KEY_W-1:0] KEY_UP       = 6'd4;
   localparam logic [KEY_W-1:0] KEY_DOWN     = 6'd5;
   localparam logic [KEY_W-1:0] KEY_SETUP    = 6'd6;
   localparam logic [KEY_W-1:0] KEY_ENTER    = 6'd7;
   localparam logic [KEY_W-1:0] KEY_REWIND   = 6'd8;
   localparam logic [KEY_W-1:0] KEY_NUM_BASE = 6'd8;
   localparam logic [KEY_W-1:0] KEY_RETURN   = 6'd33;
   localparam logic [KEY_W-1:0] KEY_PAUSE    = 6'd34;

   // Result status
   typedef enum logic [1:0] {
      STATUS_ERROR    = 2'd0,
      STATUS_FILLING  = 2'd1,
      STATUS_COMPLETE = 2'd2
   } status_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_PLAYBACK_MODE  = 2'd1
   } csr_idx_type;

   // Framer view of the byte just taken, with the key fields of the frame
   typedef struct packed {
      status_type status;
      logic [7:0] addr;
      logic [7:0] op_hi;
      logic [7:0] op_lo;
      logic [7:0] data;
   } frame_view_type;

endpackage

`default_nettype wire

### hw/rtl/kfkd_if.sv
// Valid/ready channel interfaces of the keyboard frame key decoder:
// received bytes, results and register writes. Uses kfkd_pkg.
`default_nettype none

interface kfkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_error;

   modport source (output valid, rx_byte, rx_error, input ready);
   modport sink   (input valid, rx_byte, rx_error, output ready);
endinterface

interface kfkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [5:0] key_code;

   modport source (output valid, frame_status, key_code, input ready);
   modport sink   (input valid, frame_status, key_code, output ready);
endinterface

interface kfkd_csr_if
   import kfkd_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/kfkd_framer.sv
// Frame tracker: byte counter, sync/error checks and capture of the address,
// opcode and data bytes. Uses kfkd_pkg.
`default_nettype none

module kfkd_framer
   import kfkd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           take,
   input  wire logic [7:0]     rx_byte,
   input  wire logic           rx_error,
   output frame_view_type      view
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       addr_ff, ophi_ff, oplo_ff, data_ff;
   logic             store;

   assign store = take && !rx_error;

   always_comb begin
      // Fields captured earlier, or the byte in flight when it lands on that slot
      view.addr  = (count_ff == ADDR_POS) ? rx_byte : addr_ff;
      view.op_hi = (count_ff == OPHI_POS) ? rx_byte : ophi_ff;
      view.op_lo = (count_ff == OPLO_POS) ? rx_byte : oplo_ff;
      view.data  = (count_ff == DATA_POS) ? rx_byte : data_ff;
      if (rx_error) begin
         view.status = STATUS_ERROR;
         count_in    = '0;
      end else if (count_ff == SYNC_POS && rx_byte != SYNC_BYTE) begin
         view.status = STATUS_ERROR;
         count_in    = '0;
      end else if (count_ff == LAST_POS) begin
         view.status = STATUS_COMPLETE;
         count_in    = '0;
      end else begin
         view.status = STATUS_FILLING;
         count_in    = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (take) begin
         count_ff <= count_in;
      end
   end

   // Every frame rewrites these slots before it can complete
   always_ff @(posedge clock) begin
      if (store) begin
         addr_ff <= view.addr;
         ophi_ff <= view.op_hi;
         oplo_ff <= view.op_lo;
         data_ff <= view.data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/kfkd_key_decode.sv
// Key decode of a completed frame: address match, opcode table and
// playback-only keys. Uses kfkd_pkg.
`default_nettype none

module kfkd_key_decode
   import kfkd_pkg::*;
(
   input  wire frame_view_type   view,
   input  wire logic [7:0]       device_address,
   input  wire logic             playback_mode,
   output logic [KEY_W-1:0]      key_code
);

   logic [KEY_W-1:0] op_key;
   logic [KEY_W-1:0] nav_key;

   always_comb begin
      case (view.op_lo)
         OPLO_RIGHT: nav_key = KEY_RIGHT;
         OPLO_LEFT:  nav_key = KEY_LEFT;
         OPLO_FFWD:  nav_key = playback_mode ? KEY_FFWD : KEY_NONE;
         OPLO_UP:    nav_key = KEY_UP;
         OPLO_DOWN:  nav_key = KEY_DOWN;
         OPLO_SETUP: nav_key = KEY_SETUP;
         default:    nav_key = KEY_NONE;
      endcase
   end

   always_comb begin
      unique case (view.op_hi)
         OPHI_NAV:    op_key = nav_key;
         OPHI_ENTER:  op_key = KEY_ENTER;
         OPHI_REWIND: op_key = playback_mode ? KEY_REWIND : KEY_NONE;
         OPHI_NUMBER: begin
            if (view.data >= NUM_FIRST && view.data <= NUM_LAST) begin
               op_key = KEY_NUM_BASE + view.data[KEY_W-1:0];
            end else begin
               op_key = KEY_NONE;
            end
         end
         OPHI_RETURN: op_key = KEY_RETURN;
         OPHI_PAUSE:  op_key = KEY_PAUSE;
         default:     op_key = KEY_NONE;
      endcase
   end

   // Only a complete frame for this receiver carries a key
   assign key_code = (view.status == STATUS_COMPLETE && view.addr == device_address)
                     ? op_key : KEY_NONE;

endmodule

`default_nettype wire

### hw/rtl/keyboard_frame_key_decoder.sv
// Top level of the keyboard frame key decoder: register file, framer, key
// decode and result register. Uses kfkd_pkg, kfkd_if, kfkd_framer, kfkd_key_decode.
//
//   channel   | dir | payload                      | transaction
//   req_chan  | in  | rx_byte[7:0], rx_error       | valid & ready
//   rsp_chan  | out | frame_status[1:0], key_code  | valid & ready
//   csr_chan  | in  | index[1:0], wdata[7:0]       | valid & ready (ready tied high)
//
// One result per received byte; rsp_chan.valid rises in the cycle after acceptance.
// A byte is taken every cycle while the result register is empty or drained
// in the same cycle; throughput is set by that single result register.
// Synchronous reset clears the byte counter, configuration registers and result valid.
// A stalled result holds req_chan.ready low; no byte is lost or repeated.
`default_nettype none

module keyboard_frame_key_decoder
   import kfkd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   kfkd_req_if.sink   req_chan,
   kfkd_rsp_if.source rsp_chan,
   kfkd_csr_if.sink   csr_chan
);

   logic             take;
   logic [7:0]       address_ff;
   logic             playback_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   frame_view_type   view;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff  <= '0;
         playback_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEVICE_ADDRESS: address_ff  <= csr_chan.wdata;
            CSR_PLAYBACK_MODE:  playback_ff <= csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   kfkd_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_chan.rx_byte),
      .rx_error (req_chan.rx_error),
      .view     (view)
   );

   kfkd_key_decode u_key_decode (
      .view           (view),
      .device_address (address_ff),
      .playback_mode  (playback_ff),
      .key_code       (key_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= view.status;
         key_ff    <= key_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = status_ff;
   assign rsp_chan.key_code     = key_ff;

endmodule

`default_nettype wire
